// ===== rtl/core/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types, character codes and helpers for the json string unescaper
// ----------------------------------------------------------------------------
package jsu_pkg;

	localparam int MaxResults = 6;
	localparam int CntW       = $clog2(MaxResults + 1);
	localparam int IdxW       = $clog2(MaxResults);
	localparam int HeldDigits = 3;

	// escape tracking, one-hot
	typedef enum logic [5:0] {
		PH_PLAIN = 6'b000001,
		PH_ESC   = 6'b000010,
		PH_HEX0  = 6'b000100,
		PH_HEX1  = 6'b001000,
		PH_HEX2  = 6'b010000,
		PH_HEX3  = 6'b100000
	} phase_t;

	localparam logic [7:0] ChBackslash = 8'h5C;
	localparam logic [7:0] ChQuote     = 8'h22;
	localparam logic [7:0] ChSlash     = 8'h2F;
	localparam logic [7:0] ChB         = 8'h62;
	localparam logic [7:0] ChF         = 8'h66;
	localparam logic [7:0] ChN         = 8'h6E;
	localparam logic [7:0] ChR         = 8'h72;
	localparam logic [7:0] ChT         = 8'h74;
	localparam logic [7:0] ChU         = 8'h75;

	localparam logic [7:0] CtlBs = 8'h08;
	localparam logic [7:0] CtlFf = 8'h0C;
	localparam logic [7:0] CtlLf = 8'h0A;
	localparam logic [7:0] CtlCr = 8'h0D;
	localparam logic [7:0] CtlHt = 8'h09;

	// {is_hex, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'b0;
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c inside {[8'h61:8'h66]}) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c inside {[8'h41:8'h46]}) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/json_string_unescape_core.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_core
// unescapes the body bytes of a json string into a byte stream with utf-8
// ----------------------------------------------------------------------------
// usage:
//  - input channel (in_valid/in_ready): one raw body byte per transaction,
//    in_last set on the final byte of the string body
//  - output channel (out_valid/out_ready): one result per transaction;
//    has_byte=0 marks a bare end marker, out_last flags the final result
//  - each input byte is decoded in the cycle it is accepted; its zero to six
//    result bytes land in a six-entry result buffer and the first one is
//    offered on the next cycle
//  - the result buffer drains one byte per cycle while out_ready is high;
//    a new byte is accepted when the buffer is empty or hands over its last
//    entry, so with out_ready high one byte per cycle is sustained while
//    each yields at most one result, and a byte with more stalls the input
//  - a stalled receiver simply holds the buffer: out_* stay stable and
//    in_ready drops until the buffer is down to its last entry and taken
//  - arst_n clears the escape tracking and empties the result buffer; no
//    clearing pass is needed after reset
// ----------------------------------------------------------------------------
module json_string_unescape_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       out_last
);
	import jsu_pkg::*;

	// escape tracking state
	phase_t      phase_q;
	logic [15:0] code_q;
	logic [7:0]  held_q [HeldDigits];

	// result buffer
	logic [7:0]      buf_q [MaxResults];
	logic [IdxW-1:0] rd_q;
	logic [CntW-1:0] cnt_q;
	logic            has_q;
	logic            last_q;

	// decode of the incoming byte
	phase_t      ph_n;
	logic [15:0] code_n;
	logic [15:0] cp;
	logic [7:0]  held_n [HeldDigits];
	logic [7:0]  lst [MaxResults];
	logic [CntW-1:0] n;
	logic        res_has;
	logic [4:0]  hx;
	logic [1:0]  hex_idx;
	logic [1:0]  flush_idx;
	logic        in_acc;
	logic        out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// take a new byte once the buffer is empty or hands over its last entry
	assign in_ready  = (cnt_q == '0) || (cnt_q == CntW'(1) && out_ready);
	assign out_valid = (cnt_q != '0);
	assign out_byte  = buf_q[rd_q];
	assign has_byte  = has_q;
	assign out_last  = last_q && (cnt_q == CntW'(1));

	assign hx = hex_decode(in_byte);

	// digits held so far in the current \u run
	always_comb begin
		case (phase_q)
			PH_HEX1: hex_idx = 2'd1;
			PH_HEX2: hex_idx = 2'd2;
			PH_HEX3: hex_idx = 2'd3;
			default: hex_idx = 2'd0;
		endcase
	end

	always_comb begin
		ph_n    = PH_PLAIN;
		code_n  = code_q;
		cp      = {code_q[11:0], hx[3:0]};
		held_n  = held_q;
		n       = '0;
		res_has = 1'b1;
		for (int i = 0; i < MaxResults; i++) begin
			lst[i] = 8'h00;
		end

		case (phase_q)
			PH_ESC: begin
				case (in_byte)
					ChB:         begin lst[n] = CtlBs;       n = n + 1'b1; end
					ChF:         begin lst[n] = CtlFf;       n = n + 1'b1; end
					ChN:         begin lst[n] = CtlLf;       n = n + 1'b1; end
					ChR:         begin lst[n] = CtlCr;       n = n + 1'b1; end
					ChT:         begin lst[n] = CtlHt;       n = n + 1'b1; end
					ChSlash:     begin lst[n] = ChSlash;     n = n + 1'b1; end
					ChQuote:     begin lst[n] = ChQuote;     n = n + 1'b1; end
					ChBackslash: begin lst[n] = ChBackslash; n = n + 1'b1; end
					ChU: begin
						ph_n   = PH_HEX0;
						code_n = 16'h0000;
					end
					default: begin
						// unknown escape goes out literally
						lst[n] = ChBackslash; n = n + 1'b1;
						lst[n] = in_byte;     n = n + 1'b1;
					end
				endcase
			end
			PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
				if (!hx[4]) begin
					// malformed run: replay it, then treat the byte as text
					lst[n] = ChBackslash; n = n + 1'b1;
					lst[n] = ChU;         n = n + 1'b1;
					for (int i = 0; i < HeldDigits; i++) begin
						if (2'(i) < hex_idx) begin
							lst[n] = held_q[i];
							n = n + 1'b1;
						end
					end
					if (in_byte == ChBackslash) begin
						ph_n = PH_ESC;
					end else begin
						lst[n] = in_byte;
						n = n + 1'b1;
					end
				end else if (phase_q != PH_HEX3) begin
					held_n[hex_idx] = in_byte;
					code_n = {code_q[11:0], hx[3:0]};
					case (phase_q)
						PH_HEX0: ph_n = PH_HEX1;
						PH_HEX1: ph_n = PH_HEX2;
						default: ph_n = PH_HEX3;
					endcase
				end else begin
					code_n = cp;
					// surrogates are dropped
					if (cp[15:11] != 5'b11011) begin
						if (cp < 16'h0080) begin
							lst[n] = cp[7:0]; n = n + 1'b1;
						end else if (cp < 16'h0800) begin
							lst[n] = {3'b110, cp[10:6]}; n = n + 1'b1;
							lst[n] = {2'b10, cp[5:0]};   n = n + 1'b1;
						end else begin
							lst[n] = {4'b1110, cp[15:12]}; n = n + 1'b1;
							lst[n] = {2'b10, cp[11:6]};    n = n + 1'b1;
							lst[n] = {2'b10, cp[5:0]};     n = n + 1'b1;
						end
					end
				end
			end
			default: begin
				if (in_byte == ChBackslash) begin
					ph_n = PH_ESC;
				end else begin
					lst[n] = in_byte;
					n = n + 1'b1;
				end
			end
		endcase

		// end of string: any open escape goes out literally
		if (in_last) begin
			case (ph_n)
				PH_HEX1: flush_idx = 2'd1;
				PH_HEX2: flush_idx = 2'd2;
				PH_HEX3: flush_idx = 2'd3;
				default: flush_idx = 2'd0;
			endcase
			if (ph_n != PH_PLAIN) begin
				lst[n] = ChBackslash;
				n = n + 1'b1;
			end
			if (ph_n != PH_PLAIN && ph_n != PH_ESC) begin
				lst[n] = ChU;
				n = n + 1'b1;
				for (int i = 0; i < HeldDigits; i++) begin
					if (2'(i) < flush_idx) begin
						lst[n] = held_n[i];
						n = n + 1'b1;
					end
				end
			end
			ph_n = PH_PLAIN;
			// nothing produced: a bare end marker
			if (n == '0) begin
				lst[0]  = 8'h00;
				n       = CntW'(1);
				res_has = 1'b0;
			end
		end else begin
			flush_idx = 2'd0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PLAIN;
			code_q  <= '0;
			held_q  <= '{default: '0};
			cnt_q   <= '0;
			rd_q    <= '0;
		end else begin
			if (in_acc) begin
				phase_q <= ph_n;
				code_q  <= code_n;
				held_q  <= held_n;
				cnt_q   <= n;
				rd_q    <= '0;
			end else if (out_acc) begin
				cnt_q <= cnt_q - 1'b1;
				rd_q  <= rd_q + 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			buf_q  <= lst;
			has_q  <= res_has;
			last_q <= in_last;
		end
	end

endmodule

// ===== rtl/core/jsu_checker.sv =====
// ----------------------------------------------------------------------------
// jsu_checker
// port-level checks for the json string unescaper
// ----------------------------------------------------------------------------
module jsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       has_byte,
	input logic       out_last
);

	// stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(has_byte) && $stable(out_last))
		else $error("result changed while stalled");

	// a bare end marker is always the final result of a string
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> out_last && out_byte == 8'h00)
		else $error("bare end marker not last or not zero");

	// no new byte taken while a pending result is stalled
	a_no_take_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted over a stalled result");

	// idle output buffer always takes input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty result buffer");

endmodule

bind json_string_unescape_core jsu_checker u_jsu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte),
	.has_byte  (has_byte),
	.out_last  (out_last)
);
